[src/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and widths for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int COORD_BITS = 16;
  // edge components need one more bit than a coordinate
  localparam int EDGE_BITS  = COORD_BITS + 1;
  // cross product component: twice the edge width plus a carry bit
  localparam int CROSS_BITS = 2 * EDGE_BITS + 1;
  localparam int MAG_BITS   = CROSS_BITS - 1;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int LEN_BITS   = SQ_BITS + 2;
  localparam int FRAC_SHIFT = 28;
  localparam int Q_BITS     = FRAC_SHIFT + 1;
  localparam int ROOT_BITS  = 15;
  localparam int NORM_BITS  = 16;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] v0_x;
    logic signed [COORD_BITS-1:0] v0_y;
    logic signed [COORD_BITS-1:0] v0_z;
    logic signed [COORD_BITS-1:0] v1_x;
    logic signed [COORD_BITS-1:0] v1_y;
    logic signed [COORD_BITS-1:0] v1_z;
    logic signed [COORD_BITS-1:0] v2_x;
    logic signed [COORD_BITS-1:0] v2_y;
    logic signed [COORD_BITS-1:0] v2_z;
    logic                         end_of_mesh;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_BITS-1:0] normal_x;
    logic signed [NORM_BITS-1:0] normal_y;
    logic signed [NORM_BITS-1:0] normal_z;
    logic                        degenerate;
    logic                        last_out;
  } out_item_t;

  // per-item sideband carried alongside the arithmetic
  typedef struct packed {
    logic [2:0] neg;
    logic       degenerate;
    logic       last;
  } side_t;

endpackage

[src/tfn_div_stage.sv]
// ----------------------------------------------------------------------------
// tfn_div_stage
// One restoring division step per component, registered; stalls with enable.
// ----------------------------------------------------------------------------
module tfn_div_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_in,
  input  logic [tfn_pkg::LEN_BITS-1:0]      rem_in [3],
  input  logic [tfn_pkg::Q_BITS-1:0]        q_in   [3],
  input  logic [tfn_pkg::LEN_BITS-1:0]      den_in,
  input  tfn_pkg::side_t                    side_in,
  input  logic                              shift_in,
  output logic                              vld_out,
  output logic [tfn_pkg::LEN_BITS-1:0]      rem_out [3],
  output logic [tfn_pkg::Q_BITS-1:0]        q_out   [3],
  output logic [tfn_pkg::LEN_BITS-1:0]      den_out,
  output tfn_pkg::side_t                    side_out
);

  logic [tfn_pkg::LEN_BITS-1:0] rem_r [3];
  logic [tfn_pkg::LEN_BITS-1:0] rem_nxt [3];
  logic [tfn_pkg::Q_BITS-1:0]   q_r [3];
  logic [tfn_pkg::Q_BITS-1:0]   q_nxt [3];
  logic [tfn_pkg::LEN_BITS-1:0] den_r;
  tfn_pkg::side_t               side_r;
  logic                         vld_r;

  // shift, compare, subtract for each component
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [tfn_pkg::LEN_BITS:0] r;
      r = shift_in ? {rem_in[k], 1'b0} : {1'b0, rem_in[k]};
      if (r >= {1'b0, den_in}) begin
        rem_nxt[k] = tfn_pkg::LEN_BITS'(r - {1'b0, den_in});
        q_nxt[k]   = shift_in ? {q_in[k][tfn_pkg::Q_BITS-2:0], 1'b1}
                              : {q_in[k][tfn_pkg::Q_BITS-1:1], 1'b1};
      end else begin
        rem_nxt[k] = r[tfn_pkg::LEN_BITS-1:0];
        q_nxt[k]   = shift_in ? {q_in[k][tfn_pkg::Q_BITS-2:0], 1'b0} : q_in[k];
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      den_r  <= den_in;
      side_r <= side_in;
    end
  end

  assign vld_out  = vld_r;
  assign rem_out  = rem_r;
  assign q_out    = q_r;
  assign den_out  = den_r;
  assign side_out = side_r;

endmodule

[src/tfn_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// tfn_sqrt_stage
// One digit-recurrence square root step per component, registered.
// ----------------------------------------------------------------------------
module tfn_sqrt_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [4:0]                      bit_pos,
  input  logic                            vld_in,
  input  logic [tfn_pkg::Q_BITS-1:0]      v_in   [3],
  input  logic [tfn_pkg::Q_BITS-1:0]      res_in [3],
  input  tfn_pkg::side_t                  side_in,
  output logic                            vld_out,
  output logic [tfn_pkg::Q_BITS-1:0]      v_out   [3],
  output logic [tfn_pkg::Q_BITS-1:0]      res_out [3],
  output tfn_pkg::side_t                  side_out
);

  logic [tfn_pkg::Q_BITS-1:0] v_r [3];
  logic [tfn_pkg::Q_BITS-1:0] v_nxt [3];
  logic [tfn_pkg::Q_BITS-1:0] res_r [3];
  logic [tfn_pkg::Q_BITS-1:0] res_nxt [3];
  tfn_pkg::side_t             side_r;
  logic                       vld_r;
  logic [tfn_pkg::Q_BITS-1:0] bit_w;

  assign bit_w = tfn_pkg::Q_BITS'(1) << bit_pos;

  // leading large-bit skip of the model is harmless: res stays zero there
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [tfn_pkg::Q_BITS:0] t;
      t = {1'b0, res_in[k]} + {1'b0, bit_w};
      if ({1'b0, v_in[k]} >= t) begin
        v_nxt[k]   = tfn_pkg::Q_BITS'({1'b0, v_in[k]} - t);
        res_nxt[k] = (res_in[k] >> 1) + bit_w;
      end else begin
        v_nxt[k]   = v_in[k];
        res_nxt[k] = res_in[k] >> 1;
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      v_r    <= v_nxt;
      res_r  <= res_nxt;
      side_r <= side_in;
    end
  end

  assign vld_out  = vld_r;
  assign v_out    = v_r;
  assign res_out  = res_r;
  assign side_out = side_r;

endmodule

[src/triangle_face_normal_top.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Unit face normal of a triangle, one transaction per cycle unless held by out_ready.
// ----------------------------------------------------------------------------
// A fully pipelined unit: one triangle may be accepted every cycle unless the
// pipeline holds, and its result passes through the edges, cross product and
// squares over three stages, one stage per quotient bit of the 2^28 fraction
// divide, one stage per root digit, then the output register. The whole
// pipeline advances together; when out_ready is low and the output holds a
// result, every stage holds.
module triangle_face_normal_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tfn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tfn_pkg::out_item_t out_data
);

  localparam int NDIV  = tfn_pkg::FRAC_SHIFT + 1;
  localparam int NSQRT = tfn_pkg::ROOT_BITS;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: edges
  logic signed [tfn_pkg::EDGE_BITS-1:0] s_r [3];
  logic signed [tfn_pkg::EDGE_BITS-1:0] t_r [3];
  logic                                 last1_r, vld1_r;
  // stage 2: cross product
  logic signed [tfn_pkg::CROSS_BITS-1:0] c_r [3];
  logic signed [tfn_pkg::CROSS_BITS-1:0] c_nxt [3];
  logic                                  last2_r, vld2_r;
  // stage 3: squares and length
  logic [tfn_pkg::LEN_BITS-1:0] sq_r [3];
  logic [tfn_pkg::LEN_BITS-1:0] len_r;
  logic [tfn_pkg::MAG_BITS-1:0] m [3];
  logic [tfn_pkg::SQ_BITS-1:0]  sq_w [3];
  tfn_pkg::side_t               side3_r;
  logic                         vld3_r;

  always_comb begin
    c_nxt[0] = tfn_pkg::CROSS_BITS'(s_r[1] * t_r[2]) - tfn_pkg::CROSS_BITS'(s_r[2] * t_r[1]);
    c_nxt[1] = tfn_pkg::CROSS_BITS'(s_r[2] * t_r[0]) - tfn_pkg::CROSS_BITS'(s_r[0] * t_r[2]);
    c_nxt[2] = tfn_pkg::CROSS_BITS'(s_r[0] * t_r[1]) - tfn_pkg::CROSS_BITS'(s_r[1] * t_r[0]);
    for (int k = 0; k < 3; k++) begin
      m[k] = c_r[k][tfn_pkg::CROSS_BITS-1] ? tfn_pkg::MAG_BITS'(-c_r[k])
                                           : tfn_pkg::MAG_BITS'(c_r[k]);
      // full-width square of the magnitude
      sq_w[k] = tfn_pkg::SQ_BITS'(m[k]) * tfn_pkg::SQ_BITS'(m[k]);
    end
  end

  // front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
    if (en) begin
      s_r[0] <= tfn_pkg::EDGE_BITS'(in_data.v1_x) - tfn_pkg::EDGE_BITS'(in_data.v0_x);
      s_r[1] <= tfn_pkg::EDGE_BITS'(in_data.v1_y) - tfn_pkg::EDGE_BITS'(in_data.v0_y);
      s_r[2] <= tfn_pkg::EDGE_BITS'(in_data.v1_z) - tfn_pkg::EDGE_BITS'(in_data.v0_z);
      t_r[0] <= tfn_pkg::EDGE_BITS'(in_data.v2_x) - tfn_pkg::EDGE_BITS'(in_data.v0_x);
      t_r[1] <= tfn_pkg::EDGE_BITS'(in_data.v2_y) - tfn_pkg::EDGE_BITS'(in_data.v0_y);
      t_r[2] <= tfn_pkg::EDGE_BITS'(in_data.v2_z) - tfn_pkg::EDGE_BITS'(in_data.v0_z);
      last1_r <= in_data.end_of_mesh;
      c_r     <= c_nxt;
      last2_r <= last1_r;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= tfn_pkg::LEN_BITS'(sq_w[k]);
        side3_r.neg[k] <= c_r[k][tfn_pkg::CROSS_BITS-1];
      end
      len_r <= tfn_pkg::LEN_BITS'(sq_w[0]) + tfn_pkg::LEN_BITS'(sq_w[1])
             + tfn_pkg::LEN_BITS'(sq_w[2]);
      side3_r.degenerate <= (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
      side3_r.last       <= last2_r;
    end
  end

  // divide chain
  logic                         dv   [NDIV+1];
  logic [tfn_pkg::LEN_BITS-1:0] drem [NDIV+1][3];
  logic [tfn_pkg::Q_BITS-1:0]   dq   [NDIV+1][3];
  logic [tfn_pkg::LEN_BITS-1:0] dden [NDIV+1];
  tfn_pkg::side_t               dside[NDIV+1];

  assign dv[0]    = vld3_r;
  assign drem[0]  = sq_r;
  assign dq[0]    = '{default: '0};
  assign dden[0]  = len_r;
  assign dside[0] = side3_r;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    tfn_div_stage u_div (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(dv[i]), .rem_in(drem[i]), .q_in(dq[i]), .den_in(dden[i]),
      .side_in(dside[i]), .shift_in(i != 0),
      .vld_out(dv[i+1]), .rem_out(drem[i+1]), .q_out(dq[i+1]),
      .den_out(dden[i+1]), .side_out(dside[i+1])
    );
  end

  // square root chain, bit from 2^28 down to 2^0, a factor of four per stage
  logic                       sv   [NSQRT+1];
  logic [tfn_pkg::Q_BITS-1:0] sval [NSQRT+1][3];
  logic [tfn_pkg::Q_BITS-1:0] sres [NSQRT+1][3];
  tfn_pkg::side_t             sside[NSQRT+1];

  assign sv[0]    = dv[NDIV];
  assign sval[0]  = dq[NDIV];
  assign sres[0]  = '{default: '0};
  assign sside[0] = dside[NDIV];

  for (genvar j = 0; j < NSQRT; j++) begin : g_sqrt
    tfn_sqrt_stage u_sqrt (
      .clk(clk), .rst_n(rst_n), .en(en), .bit_pos(5'(2 * (NSQRT - 1 - j))),
      .vld_in(sv[j]), .v_in(sval[j]), .res_in(sres[j]), .side_in(sside[j]),
      .vld_out(sv[j+1]), .v_out(sval[j+1]), .res_out(sres[j+1]),
      .side_out(sside[j+1])
    );
  end

  // output register with sign and degenerate handling
  tfn_pkg::out_item_t out_r, out_nxt;
  logic               out_vld_r;
  logic [tfn_pkg::NORM_BITS-1:0] nrm [3];

  always_comb begin
    tfn_pkg::side_t sd;
    sd = sside[NSQRT];
    for (int k = 0; k < 3; k++) begin
      logic [tfn_pkg::NORM_BITS-1:0] mg;
      mg = tfn_pkg::NORM_BITS'(sres[NSQRT][k]);
      if (sd.degenerate) nrm[k] = '0;
      else if (sd.neg[k]) nrm[k] = -mg;
      else nrm[k] = mg;
    end
    out_nxt.normal_x   = nrm[0];
    out_nxt.normal_y   = nrm[1];
    out_nxt.normal_z   = nrm[2];
    out_nxt.degenerate = sd.degenerate;
    out_nxt.last_out   = sd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sv[NSQRT];
    end
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[verif/triangle_face_normal_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_top_tb
// Streams triangles through the face normal unit and compares every result
// with a local integer model of the cross product, normalise and root.
// ----------------------------------------------------------------------------
module triangle_face_normal_top_tb;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  tfn_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  tfn_pkg::out_item_t out_data;

  tfn_pkg::out_item_t normal_q[$];
  int                 errors;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  triangle_face_normal_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // clock
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // floor(n * 2^28 / d) by restoring division, n <= d
  function automatic logic [31:0] scaled_ratio(logic [127:0] n, logic [127:0] d);
    logic [127:0] r;
    logic [31:0]  q;
    r = n;
    q = 0;
    if (r >= d) begin
      r = r - d;
      q = 1;
    end
    for (int i = 0; i < tfn_pkg::FRAC_SHIFT; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // integer square root, digit by digit
  function automatic logic [31:0] int_root(logic [31:0] v);
    logic [31:0] res;
    logic [31:0] b;
    res = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // expected unit normal of one triangle
  function automatic tfn_pkg::out_item_t face_normal(tfn_pkg::in_item_t t);
    tfn_pkg::out_item_t r;
    longint             s[3], e[3], c[3], p[9];
    logic [127:0]       sq[3], len;
    longint             n;
    p[0] = t.v0_x; p[1] = t.v0_y; p[2] = t.v0_z;
    p[3] = t.v1_x; p[4] = t.v1_y; p[5] = t.v1_z;
    p[6] = t.v2_x; p[7] = t.v2_y; p[8] = t.v2_z;
    for (int k = 0; k < 3; k++) begin
      s[k] = p[3+k] - p[k];
      e[k] = p[6+k] - p[k];
    end
    c[0] = s[1]*e[2] - s[2]*e[1];
    c[1] = s[2]*e[0] - s[0]*e[2];
    c[2] = s[0]*e[1] - s[1]*e[0];
    len = 0;
    for (int k = 0; k < 3; k++) begin
      n = (c[k] < 0) ? -c[k] : c[k];
      sq[k] = 128'(n) * 128'(n);
      len = len + sq[k];
    end
    r = '0;
    if (len == 0) begin
      r.degenerate = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) begin
        n = int_root(scaled_ratio(sq[k], len));
        if (c[k] < 0) n = -n;
        if (k == 0) r.normal_x = n[15:0];
        else if (k == 1) r.normal_y = n[15:0];
        else r.normal_z = n[15:0];
      end
    end
    r.last_out = t.end_of_mesh;
    return r;
  endfunction

  // send one triangle, with random idle cycles beforehand
  task automatic send_triangle(tfn_pkg::in_item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    normal_q.push_back(face_normal(t));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic tfn_pkg::in_item_t rand_triangle();
    tfn_pkg::in_item_t t;
    t = tfn_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    t.end_of_mesh = ($urandom_range(15) == 0);
    return t;
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    tfn_pkg::out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (normal_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_r = normal_q.pop_front();
        if (exp_r.normal_x !== out_data.normal_x)
          $display("%0t: normal_x expected %0d actual %0d", $time,
                   exp_r.normal_x, out_data.normal_x);
        if (exp_r.normal_y !== out_data.normal_y)
          $display("%0t: normal_y expected %0d actual %0d", $time,
                   exp_r.normal_y, out_data.normal_y);
        if (exp_r.normal_z !== out_data.normal_z)
          $display("%0t: normal_z expected %0d actual %0d", $time,
                   exp_r.normal_z, out_data.normal_z);
        if (exp_r.degenerate !== out_data.degenerate)
          $display("%0t: degenerate expected %0b actual %0b", $time,
                   exp_r.degenerate, out_data.degenerate);
        if (exp_r.last_out !== out_data.last_out)
          $display("%0t: last_out expected %0b actual %0b", $time,
                   exp_r.last_out, out_data.last_out);
        if (exp_r !== out_data) errors++;
      end
    end
  end

  // extremes, axis-aligned faces and degenerate shapes
  task automatic test_directed();
    tfn_pkg::in_item_t t;
    t = '0;
    send_triangle(t);
    t = '0; t.v1_x = 16'sd256; t.v2_y = 16'sd256;
    send_triangle(t);
    t = '0; t.v1_y = 16'sd256; t.v2_z = 16'sd256;
    send_triangle(t);
    t = '0; t.v1_z = 16'sd256; t.v2_x = 16'sd256; t.end_of_mesh = 1'b1;
    send_triangle(t);
    t = '0; t.v1_x = 16'sd256; t.v2_x = -16'sd512;
    send_triangle(t);
    t = '0; t.v0_x = 16'sh7fff; t.v0_y = 16'sh7fff; t.v0_z = 16'sh7fff;
    t.v1_x = -16'sh8000; t.v1_y = 16'sh7fff; t.v1_z = -16'sh8000;
    t.v2_x = -16'sh8000; t.v2_y = -16'sh8000; t.v2_z = 16'sh7fff;
    send_triangle(t);
    t = {{9{16'sh8000}}, 1'b1};
    send_triangle(t);
    t = {{9{16'sh7fff}}, 1'b0};
    send_triangle(t);
    t = '0; t.v0_x = -16'sh8000; t.v1_y = 16'sh7fff; t.v2_z = 16'sh7fff;
    send_triangle(t);
    t = '0; t.v0_x = 16'sh7fff; t.v1_y = -16'sh8000; t.v2_z = -16'sh8000;
    send_triangle(t);
    t = '0; t.v1_x = 16'sd1; t.v1_y = 16'sd1; t.v1_z = 16'sd1;
    t.v2_x = -16'sd1; t.v2_y = 16'sd1;
    send_triangle(t);
    t = '1;
    send_triangle(t);
  endtask

  // random triangles, small and full-range, some degenerate
  task automatic test_random(int count);
    tfn_pkg::in_item_t t;
    for (int i = 0; i < count; i++) begin
      t = rand_triangle();
      case ($urandom_range(3))
        0: begin
          t.v1_x = t.v0_x + 16'($signed($urandom_range(64)) - 32);
          t.v2_y = t.v0_y + 16'($signed($urandom_range(64)) - 32);
          t.v1_z = t.v0_z; t.v2_z = t.v0_z;
        end
        1: begin
          t.v1_x = t.v0_x; t.v1_y = t.v0_y; t.v1_z = t.v0_z;
        end
        default: ;
      endcase
      send_triangle(t);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(400);
    send_idle_pct = 69;
    test_random(400);
    send_idle_pct = 0; recv_stall_pct = 69;
    test_random(400);
    send_idle_pct = 18; recv_stall_pct = 18;
    test_random(440);
    wait_drained();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
